// File: design/c8fx_pkg.sv
// c8fx_pkg: shared types and codes for the chip-8 fx-group executor
// transfer structs, action and opcode codes, controller/datapath command and status
// no dependencies
package c8fx_pkg;

	// input item, one transfer per accepted start
	typedef struct packed {
		logic [2:0]  action;
		logic [15:0] opcode;
		logic [15:0] keys_down;
		logic [11:0] target_addr;
		logic [7:0]  write_byte;
	} item_t;

	// result item, one transfer per item
	typedef struct packed {
		logic        repeat_instr;
		logic        unknown_op;
		logic [7:0]  read_byte;
		logic [15:0] index_now;
		logic [7:0]  delay_now;
		logic [7:0]  sound_now;
	} result_t;

	// actions
	localparam logic [2:0] ACT_EXEC  = 3'd0;
	localparam logic [2:0] ACT_MEMWR = 3'd1;
	localparam logic [2:0] ACT_REGWR = 3'd2;
	localparam logic [2:0] ACT_MEMRD = 3'd3;
	localparam logic [2:0] ACT_REGRD = 3'd4;

	// opcode groups (top nibble)
	localparam logic [3:0] GRP_LDI = 4'hA;
	localparam logic [3:0] GRP_FX  = 4'hF;

	// fx low bytes
	localparam logic [7:0] FX_LD_VDT  = 8'h07;
	localparam logic [7:0] FX_LD_KEY  = 8'h0A;
	localparam logic [7:0] FX_LD_DTV  = 8'h15;
	localparam logic [7:0] FX_LD_STV  = 8'h18;
	localparam logic [7:0] FX_ADD_I   = 8'h1E;
	localparam logic [7:0] FX_LD_FONT = 8'h29;
	localparam logic [7:0] FX_BCD     = 8'h33;
	localparam logic [7:0] FX_STORE   = 8'h55;
	localparam logic [7:0] FX_LOAD    = 8'h65;

	localparam logic [15:0] LDI_MASK = 16'h0FFF;

	// work kinds reported to the controller
	localparam logic [2:0] K_SINGLE = 3'd0;
	localparam logic [2:0] K_MEMRD  = 3'd1;
	localparam logic [2:0] K_BCD    = 3'd2;
	localparam logic [2:0] K_STORE  = 3'd3;
	localparam logic [2:0] K_LOAD   = 3'd4;

	// index of the last byte written by the bcd instruction
	localparam logic [4:0] BCD_LAST = 5'd2;

	typedef struct packed {
		logic       load;     // latch the new item
		logic       exec;     // work of a latched item of kind single
		logic       mem_we;   // memory write at index + idx (bcd, store)
		logic       mem_re;   // memory read issue
		logic       reg_fill; // register fidx takes the memory read data
		logic       capture;  // read_byte takes the memory read data
		logic       finish;   // register the result
		logic [3:0] idx;
		logic [3:0] fidx;
	} cmd_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [3:0] x;
	} stat_t;

endpackage

// File: design/c8fx_dp.sv
// c8fx_dp: datapath of the chip-8 fx-group executor
// register file, index and timers, 4 KB byte memory, decode and result register
// depends on c8fx_pkg
module c8fx_dp import c8fx_pkg::*; #(
	parameter int MEM_BYTES = 4096,
	parameter int NUM_REGS  = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  item_t   item,
	input  cmd_t    cmd,
	output stat_t   stat,
	output result_t result
);

	localparam int AW = $clog2(MEM_BYTES);
	localparam int RW = $clog2(NUM_REGS);

	item_t       item_q;
	logic [7:0]  gp_q [NUM_REGS];
	logic [15:0] index_q;
	logic [7:0]  delay_q;
	logic [7:0]  sound_q;
	logic [7:0]  rb_q;
	logic [7:0]  rdata_q;
	logic [7:0]  mem [MEM_BYTES];
	result_t     result_q;

	logic [2:0]    act;
	logic [15:0]   opc;
	logic [7:0]    lo;
	logic [RW-1:0] x;
	logic          is_ldi;
	logic          is_fx;
	logic          fx_known;
	logic          rep;
	logic          unk;
	logic [2:0]    kind;
	logic [RW-1:0] rsel;
	logic [7:0]    vsel;
	logic [AW-1:0] maddr;
	logic [7:0]    mwdata;
	logic          mem_we;
	logic [11:0]   digits;
	logic [7:0]    digit;

	function automatic logic [3:0] lowest_key(input logic [15:0] keys);
		logic [3:0] r;
		r = '0;
		for (int i = 15; i >= 0; i--) begin
			if (keys[i]) r = 4'(i);
		end
		return r;
	endfunction

	// hundreds, tens, ones of a byte by compares
	function automatic logic [11:0] bcd_of(input logic [7:0] v);
		logic [3:0] h;
		logic [3:0] t;
		logic [7:0] rem;
		logic [7:0] ones;
		if (v >= 8'd200) begin
			h = 4'd2;
			rem = v - 8'd200;
		end else if (v >= 8'd100) begin
			h = 4'd1;
			rem = v - 8'd100;
		end else begin
			h = 4'd0;
			rem = v;
		end
		t = '0;
		for (int k = 1; k < 10; k++) begin
			if (rem >= 8'(k * 10)) t = 4'(k);
		end
		ones = rem - 8'({t, 3'b000} + {t, 1'b0});
		return {h, t, ones[3:0]};
	endfunction

	assign act    = item_q.action;
	assign opc    = item_q.opcode;
	assign lo     = opc[7:0];
	assign x      = opc[8 +: RW];
	assign is_ldi = (act == ACT_EXEC) && (opc[15:12] == GRP_LDI);
	assign is_fx  = (act == ACT_EXEC) && (opc[15:12] == GRP_FX);

	always_comb begin
		unique case (lo) inside
			FX_LD_VDT, FX_LD_KEY, FX_LD_DTV, FX_LD_STV, FX_ADD_I,
			FX_LD_FONT, FX_BCD, FX_STORE, FX_LOAD: fx_known = 1'b1;
			default:                                fx_known = 1'b0;
		endcase
	end

	assign unk = (act == ACT_EXEC) && !is_ldi && !(is_fx && fx_known);
	assign rep = is_fx && (lo == FX_LD_KEY) && (item_q.keys_down == '0);

	always_comb begin
		kind = K_SINGLE;
		if (act == ACT_MEMRD) begin
			kind = K_MEMRD;
		end else if (is_fx) begin
			unique case (lo)
				FX_BCD:   kind = K_BCD;
				FX_STORE: kind = K_STORE;
				FX_LOAD:  kind = K_LOAD;
				default:  kind = K_SINGLE;
			endcase
		end
	end

	assign stat.kind = kind;
	assign stat.x    = 4'(x);

	// one register read port, address picked by the work in progress
	always_comb begin
		if (kind == K_STORE) rsel = cmd.idx[RW-1:0];
		else if (act == ACT_REGRD) rsel = item_q.target_addr[RW-1:0];
		else rsel = x;
	end
	assign vsel = gp_q[rsel];

	assign digits = bcd_of(vsel);
	always_comb begin
		case (cmd.idx[1:0])
			2'd0:    digit = {4'b0000, digits[11:8]};
			2'd1:    digit = {4'b0000, digits[7:4]};
			default: digit = {4'b0000, digits[3:0]};
		endcase
	end

	always_comb begin
		if ((act == ACT_MEMWR) || (act == ACT_MEMRD)) maddr = item_q.target_addr[AW-1:0];
		else maddr = index_q[AW-1:0] + AW'(cmd.idx);
	end

	always_comb begin
		if (kind == K_BCD) mwdata = digit;
		else if (act == ACT_MEMWR) mwdata = item_q.write_byte;
		else mwdata = vsel;
	end

	assign mem_we = cmd.mem_we || (cmd.exec && (act == ACT_MEMWR));

	always_ff @(posedge clk) begin
		if (mem_we) mem[maddr] <= mwdata;
		if (cmd.mem_re) rdata_q <= mem[maddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) item_q <= item;
		if (cmd.load) rb_q <= '0;
		else if (cmd.capture) rb_q <= rdata_q;
		else if (cmd.exec && (act == ACT_REGRD)) rb_q <= vsel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) gp_q[i] <= '0;
			index_q <= '0;
			delay_q <= '0;
			sound_q <= '0;
		end else begin
			if (cmd.reg_fill) gp_q[cmd.fidx[RW-1:0]] <= rdata_q;
			if (cmd.exec) begin
				if (act == ACT_REGWR) gp_q[item_q.target_addr[RW-1:0]] <= item_q.write_byte;
				if (is_ldi) index_q <= opc & LDI_MASK;
				if (is_fx) begin
					case (lo)
						FX_LD_VDT: gp_q[x] <= delay_q;
						FX_LD_KEY: begin
							if (!rep) gp_q[x] <= {4'b0000, lowest_key(item_q.keys_down)};
						end
						FX_LD_DTV:  delay_q <= vsel;
						FX_LD_STV:  sound_q <= vsel;
						FX_ADD_I:   index_q <= index_q + {8'b0, vsel};
						FX_LD_FONT: index_q <= {6'b0, vsel, 2'b00} + {8'b0, vsel};
						default: ;
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			result_q.repeat_instr <= rep;
			result_q.unknown_op   <= unk;
			result_q.read_byte    <= rb_q;
			result_q.index_now    <= index_q;
			result_q.delay_now    <= delay_q;
			result_q.sound_now    <= sound_q;
		end
	end

	assign result = result_q;

endmodule

// File: design/c8fx_ctrl.sv
// c8fx_ctrl: sequencing state machine of the chip-8 fx-group executor
// drives datapath commands from the decoded kind, counts block moves and bcd bytes
// depends on c8fx_pkg
module c8fx_ctrl import c8fx_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  stat_t stat,
	output logic  busy,
	output logic  done,
	output cmd_t  cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEC  = 3'd1;
	localparam logic [2:0] S_BCD  = 3'd2;
	localparam logic [2:0] S_STO  = 3'd3;
	localparam logic [2:0] S_LDM  = 3'd4;
	localparam logic [2:0] S_MCAP = 3'd5;
	localparam logic [2:0] S_FIN  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [4:0] cnt_q;
	logic [4:0] cnt_d;
	logic       done_q;
	logic [4:0] x_ext;

	assign x_ext = {1'b0, stat.x};
	assign busy  = (state_q != S_IDLE);
	assign done  = done_q;

	always_comb begin
		cmd      = '0;
		cmd.idx  = cnt_q[3:0];
		cmd.fidx = cnt_q[3:0] - 4'd1;
		state_d  = state_q;
		cnt_d    = cnt_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DEC;
				end
			end
			S_DEC: begin
				cnt_d = '0;
				unique case (stat.kind)
					K_MEMRD: begin
						cmd.mem_re = 1'b1;
						state_d    = S_MCAP;
					end
					K_BCD:   state_d = S_BCD;
					K_STORE: state_d = S_STO;
					K_LOAD:  state_d = S_LDM;
					default: begin
						cmd.exec = 1'b1;
						state_d  = S_FIN;
					end
				endcase
			end
			S_BCD: begin
				cmd.mem_we = 1'b1;
				cnt_d      = cnt_q + 5'd1;
				if (cnt_q == BCD_LAST) state_d = S_FIN;
			end
			S_STO: begin
				cmd.mem_we = 1'b1;
				cnt_d      = cnt_q + 5'd1;
				if (cnt_q == x_ext) state_d = S_FIN;
			end
			S_LDM: begin
				// read of byte i overlaps the register write of byte i-1
				cmd.mem_re   = (cnt_q <= x_ext);
				cmd.reg_fill = (cnt_q != '0);
				cnt_d        = cnt_q + 5'd1;
				if (cnt_q == x_ext + 5'd1) state_d = S_FIN;
			end
			S_MCAP: begin
				cmd.capture = 1'b1;
				state_d     = S_FIN;
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			done_q  <= cmd.finish;
		end
	end

	a_fin_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN |=> done_q)
		else $error("finish state not followed by result strobe");

	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q) == S_FIN)
		else $error("result strobe without finish state");

	a_mem_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.mem_we && cmd.mem_re))
		else $error("memory read and write in one cycle");

	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> state_q == S_DEC)
		else $error("accepted item did not enter decode");

	a_fill_ldm: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.reg_fill |-> state_q == S_LDM && $past(cmd.mem_re))
		else $error("register fill without a preceding memory read");

endmodule

// File: design/chip8_fx_group_executor_top.sv
// chip8_fx_group_executor_top: chip-8 annn and fx-group instruction executor
// channel    direction  handshake            payload
// item       in         start && !busy       item_t   (action, opcode, keys, addr, byte)
// result     out        done, one cycle      result_t (flags, read byte, index, timers)
// an item passes from the accept edge through decode, its work and the finish state to the
// result transfer, the work of fx55 and fx65 covering registers 0..x (x = opcode bits
// 11..8); the block moves and bcd go one byte a cycle through the
// single memory port. busy is high from the accept edge until the result cycle, in
// which a new item may already be taken. reset clears registers, index and timers;
// memory has no reset. the receiver cannot stall: done is high for exactly one cycle.
// depends on c8fx_pkg, c8fx_ctrl, c8fx_dp
module chip8_fx_group_executor_top import c8fx_pkg::*; #(
	parameter int MEM_BYTES = 4096,
	parameter int NUM_REGS  = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  item_t   item,
	output logic    done,
	output result_t result
);

	cmd_t  cmd;
	stat_t stat;

	c8fx_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	c8fx_dp #(
		.MEM_BYTES (MEM_BYTES),
		.NUM_REGS  (NUM_REGS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.stat   (stat),
		.result (result)
	);

endmodule

// File: test/chip8_fx_group_executor_top_tb.sv
// testbench for chip8_fx_group_executor_top: directed and random annn/fx-group items
// checked against a shadow copy of registers, index, timers and memory
// depends on c8fx_pkg and the design files
module chip8_fx_group_executor_top_tb;
	import c8fx_pkg::*;

	localparam int N_ITEMS     = 750;
	localparam int CYCLE_LIMIT = 200000;
	localparam int TAIL_CYCLES = 30;
	localparam int PHASE_LEN   = 185;

	typedef struct {
		item_t   it;
		result_t want;
		int      idle;
		bit      drain;
	} stim_t;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	item_t   item;
	logic    done;
	result_t result;

	// shadow machine state
	logic [7:0]  v_regs [16];
	logic [15:0] idx_reg;
	logic [7:0]  dly;
	logic [7:0]  snd;
	logic [7:0]  mem_img [4096];
	bit          mem_ok [4096];
	logic [11:0] written [$];

	stim_t   item_backlog [$];
	result_t pending_status [$];
	stim_t   in_flight;
	bit      taken;
	bit      next_drain;
	int      cur_idle;
	int      n_items;
	int      n_results;
	int      fails;
	int      cycle_count;

	chip8_fx_group_executor_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic void put_byte(input int unsigned a, input logic [7:0] b);
		mem_img[a % 4096] = b;
		if (!mem_ok[a % 4096]) begin
			mem_ok[a % 4096] = 1'b1;
			written.push_back(12'(a % 4096));
		end
	endfunction

	// applies one item to the shadow state and returns the status it should report
	function automatic result_t run_chip8_step(input item_t it);
		result_t r;
		logic [3:0] x;
		logic [7:0] v;
		r = '0;
		v = '0;
		x = it.opcode[11:8];
		case (it.action)
			ACT_EXEC: begin
				if (it.opcode[15:12] == GRP_LDI)
					idx_reg = it.opcode & LDI_MASK;
				else if (it.opcode[15:12] != GRP_FX)
					r.unknown_op = 1'b1;
				else case (it.opcode[7:0])
					FX_LD_VDT: v_regs[x] = dly;
					FX_LD_KEY: begin
						if (it.keys_down == '0)
							r.repeat_instr = 1'b1;
						else begin
							for (int k = 15; k >= 0; k--)
								if (it.keys_down[k]) v = 8'(k);
							v_regs[x] = v;
						end
					end
					FX_LD_DTV:  dly = v_regs[x];
					FX_LD_STV:  snd = v_regs[x];
					FX_ADD_I:   idx_reg = idx_reg + 16'(v_regs[x]);
					FX_LD_FONT: idx_reg = 16'(v_regs[x]) * 16'd5;
					FX_BCD: begin
						v = v_regs[x];
						put_byte(32'(idx_reg), 8'(v / 100));
						put_byte(idx_reg + 1, 8'((v / 10) % 10));
						put_byte(idx_reg + 2, 8'(v % 10));
					end
					FX_STORE:
						for (int i = 0; i <= x; i++) put_byte(idx_reg + i, v_regs[i]);
					FX_LOAD:
						for (int i = 0; i <= x; i++) v_regs[i] = mem_img[(idx_reg + i) % 4096];
					default: r.unknown_op = 1'b1;
				endcase
			end
			ACT_MEMWR: put_byte(32'(it.target_addr), it.write_byte);
			ACT_REGWR: v_regs[it.target_addr[3:0]] = it.write_byte;
			ACT_MEMRD: r.read_byte = mem_img[it.target_addr];
			ACT_REGRD: r.read_byte = v_regs[it.target_addr[3:0]];
			default: ;
		endcase
		r.index_now = idx_reg;
		r.delay_now = dly;
		r.sound_now = snd;
		return r;
	endfunction

	function automatic item_t mk(input logic [2:0] a, input logic [15:0] op,
			input logic [15:0] k, input logic [11:0] ad, input logic [7:0] b);
		item_t it;
		it.action = a;
		it.opcode = op;
		it.keys_down = k;
		it.target_addr = ad;
		it.write_byte = b;
		return it;
	endfunction

	function automatic item_t rnd_item();
		return mk(3'($urandom), 16'($urandom), 16'($urandom), 12'($urandom), 8'($urandom));
	endfunction

	function automatic item_t rnd_exec(input logic [15:0] op);
		item_t it;
		it = rnd_item();
		it.action = ACT_EXEC;
		it.opcode = op;
		return it;
	endfunction

	// memory is only ever read where it has been written
	task automatic queue_item(input item_t it);
		stim_t s;
		int n;
		if (it.action == ACT_MEMRD && !mem_ok[it.target_addr]) begin
			if (written.size() == 0)
				it.action = ACT_MEMWR;
			else
				it.target_addr = written[$urandom_range(written.size() - 1)];
		end
		if (it.action == ACT_EXEC && it.opcode[15:12] == GRP_FX && it.opcode[7:0] == FX_LOAD) begin
			n = 0;
			while (n <= it.opcode[11:8] && mem_ok[(idx_reg + n) % 4096]) n++;
			if (n == 0)
				it.opcode[7:0] = FX_STORE;
			else
				it.opcode[11:8] = 4'(n - 1);
		end
		s.it = it;
		s.want = run_chip8_step(it);
		s.idle = cur_idle;
		s.drain = next_drain;
		next_drain = 1'b0;
		item_backlog.push_back(s);
		n_items++;
	endtask

	function automatic void compare_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fails++;
		end
	endfunction

	// driver: a new item goes out once the previous one is transferred
	always @(negedge clk) begin
		if (arst_n && (!start || taken)) begin
			if (item_backlog.size() != 0
					&& !(item_backlog[0].drain && pending_status.size() != 0)
					&& $urandom_range(99) >= item_backlog[0].idle) begin
				in_flight = item_backlog.pop_front();
				item <= in_flight.it;
				start <= 1'b1;
			end else
				start <= 1'b0;
		end
	end

	// monitor: check results, then record the item transferred at this edge
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (done) begin
				if (pending_status.size() == 0) begin
					$error("result transfer with nothing expected");
					fails++;
				end else begin
					want = pending_status.pop_front();
					compare_field("repeat_instr", 16'(want.repeat_instr),
						16'(result.repeat_instr));
					compare_field("unknown_op", 16'(want.unknown_op), 16'(result.unknown_op));
					compare_field("read_byte", 16'(want.read_byte), 16'(result.read_byte));
					compare_field("index_now", want.index_now, result.index_now);
					compare_field("delay_now", 16'(want.delay_now), 16'(result.delay_now));
					compare_field("sound_now", 16'(want.sound_now), 16'(result.sound_now));
					n_results++;
				end
			end
			taken = start && !busy;
			if (taken) pending_status.push_back(in_flight.want);
		end else
			taken = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		item_t it;
		logic [3:0] x;
		logic [3:0] y;
		logic [15:0] keys;
		int ph;
		int last_ph;
		bit ramp_done;
		start = 1'b0;
		item = '0;
		arst_n = 1'b0;
		taken = 1'b0;
		n_items = 0;
		n_results = 0;
		fails = 0;
		cycle_count = 0;
		cur_idle = 0;
		next_drain = 1'b0;
		idx_reg = '0;
		dly = '0;
		snd = '0;
		for (int i = 0; i < 16; i++) v_regs[i] = '0;
		for (int i = 0; i < 4096; i++) begin
			mem_img[i] = '0;
			mem_ok[i] = 1'b0;
		end

		// directed: field extremes, every operation, wraps and the odd cases
		queue_item(mk(ACT_REGWR, 16'hFFFF, 16'hFFFF, 12'hFF5, 8'hFF));  // upper addr bits ignored
		queue_item(mk(ACT_REGRD, 16'h0000, 16'h0000, 12'h005, 8'h00));
		queue_item(mk(ACT_REGWR, 16'h0000, 16'h0000, 12'h00F, 8'h7E));
		queue_item(mk(ACT_EXEC, 16'hAFFF, 16'h0000, 12'h000, 8'h00));
		queue_item(mk(ACT_EXEC, {GRP_FX, 4'h5, FX_BCD}, 16'h0000, 12'h000, 8'h00));
		queue_item(mk(ACT_MEMRD, 16'h0000, 16'h0000, 12'hFFF, 8'h00));
		queue_item(mk(ACT_MEMRD, 16'h0000, 16'h0000, 12'h001, 8'h00));
		queue_item(mk(ACT_EXEC, {GRP_FX, 4'h5, FX_LD_DTV}, 16'h0000, 12'h000, 8'h00));
		queue_item(mk(ACT_EXEC, {GRP_FX, 4'h5, FX_LD_STV}, 16'h0000, 12'h000, 8'h00));
		queue_item(mk(ACT_EXEC, {GRP_FX, 4'h0, FX_LD_VDT}, 16'h0000, 12'h000, 8'h00));
		queue_item(mk(ACT_EXEC, {GRP_FX, 4'h0, FX_LD_KEY}, 16'h0000, 12'h000, 8'h00));
		queue_item(mk(ACT_EXEC, {GRP_FX, 4'h3, FX_LD_KEY}, 16'h8000, 12'h000, 8'h00));
		queue_item(mk(ACT_EXEC, {GRP_FX, 4'h2, FX_LD_KEY}, 16'hFFFF, 12'h000, 8'h00));
		queue_item(mk(ACT_EXEC, {GRP_FX, 4'hF, FX_STORE}, 16'h0000, 12'h000, 8'h00));
		queue_item(mk(ACT_EXEC, 16'hA000, 16'h0000, 12'h000, 8'h00));
		queue_item(mk(ACT_EXEC, {GRP_FX, 4'hE, FX_LOAD}, 16'h0000, 12'h000, 8'h00));
		queue_item(mk(ACT_EXEC, {GRP_FX, 4'h5, FX_ADD_I}, 16'h0000, 12'h000, 8'h00));
		queue_item(mk(ACT_EXEC, {GRP_FX, 4'h5, FX_LD_FONT}, 16'h0000, 12'h000, 8'h00));
		queue_item(mk(ACT_EXEC, 16'h0000, 16'h0000, 12'h000, 8'h00));
		queue_item(mk(ACT_EXEC, 16'hFFFF, 16'h0000, 12'h000, 8'h00));
		queue_item(mk(ACT_EXEC, 16'hB123, 16'h0000, 12'h000, 8'h00));
		queue_item(mk(3'd5, 16'hFFFF, 16'hFFFF, 12'hFFF, 8'hFF));
		queue_item(mk(3'd7, 16'hFFFF, 16'hFFFF, 12'hFFF, 8'hFF));
		queue_item(mk(ACT_MEMWR, 16'h0000, 16'h0000, 12'hFFF, 8'hFF));
		queue_item(mk(ACT_MEMRD, 16'hFFFF, 16'hFFFF, 12'hFFF, 8'h00));

		last_ph = -1;
		ramp_done = 1'b0;
		while (n_items < N_ITEMS) begin
			ph = (n_items - 25) / PHASE_LEN;
			if (ph > 3) ph = 3;
			if (ph != last_ph) begin
				last_ph = ph;
				next_drain = 1'b1;
				case (ph)
					1: cur_idle = 54;
					3: cur_idle = 37;
					default: cur_idle = 0;
				endcase
			end
			x = 4'($urandom_range(15));
			if (!ramp_done && n_items >= 400) begin
				// walk the index past 16 bits, with block moves at high addresses
				ramp_done = 1'b1;
				queue_item(rnd_exec({GRP_LDI, 12'hFFF}));
				queue_item(mk(ACT_REGWR, 16'($urandom), 16'($urandom), 12'h007, 8'hFF));
				for (int k = 0; k < 245; k++) begin
					queue_item(rnd_exec({GRP_FX, 4'h7, FX_ADD_I}));
					if (k % 40 == 20) begin
						y = 4'($urandom_range(6));
						queue_item(rnd_exec({GRP_FX, y, FX_STORE}));
						queue_item(rnd_exec({GRP_FX, 4'($urandom_range(y)), FX_LOAD}));
					end
				end
			end else case ($urandom_range(99)) inside
				[0:11]: begin
					it = rnd_item();
					it.action = ACT_MEMWR;
					queue_item(it);
				end
				[12:21]: begin
					it = rnd_item();
					it.action = ACT_REGWR;
					queue_item(it);
				end
				[22:29]: begin
					it = rnd_item();
					it.action = ACT_MEMRD;
					queue_item(it);
				end
				[30:36]: begin
					it = rnd_item();
					it.action = ACT_REGRD;
					queue_item(it);
				end
				[37:39]: begin
					it = rnd_item();
					it.action = 3'($urandom_range(7, 5));
					queue_item(it);
				end
				[40:45]: begin
					if ($urandom_range(1))
						queue_item(rnd_exec(16'($urandom)));
					else
						queue_item(rnd_exec({GRP_FX, x, 8'($urandom)}));
				end
				[46:59]: begin
					queue_item(rnd_exec({GRP_LDI, 12'($urandom)}));
					if ($urandom_range(1)) begin
						queue_item(rnd_exec({GRP_FX, x, FX_STORE}));
						queue_item(rnd_exec({GRP_FX, 4'($urandom_range(x)), FX_LOAD}));
					end else begin
						queue_item(rnd_exec({GRP_FX, x, FX_BCD}));
						queue_item(rnd_exec({GRP_FX, 4'($urandom_range(2)), FX_LOAD}));
					end
				end
				default: begin
					case ($urandom_range(9))
						0: queue_item(rnd_exec({GRP_LDI, 12'($urandom)}));
						1: queue_item(rnd_exec({GRP_FX, x, FX_LD_VDT}));
						2: begin
							case ($urandom_range(3))
								0: keys = '0;
								1: keys = 16'd1 << $urandom_range(15);
								default: keys = 16'($urandom);
							endcase
							it = rnd_exec({GRP_FX, x, FX_LD_KEY});
							it.keys_down = keys;
							queue_item(it);
						end
						3: queue_item(rnd_exec({GRP_FX, x, FX_LD_DTV}));
						4: queue_item(rnd_exec({GRP_FX, x, FX_LD_STV}));
						5: queue_item(rnd_exec({GRP_FX, x, FX_ADD_I}));
						6: queue_item(rnd_exec({GRP_FX, x, FX_LD_FONT}));
						7: queue_item(rnd_exec({GRP_FX, x, FX_BCD}));
						8: queue_item(rnd_exec({GRP_FX, x, FX_STORE}));
						default: queue_item(rnd_exec({GRP_FX, x, FX_LOAD}));
					endcase
				end
			endcase
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (item_backlog.size() != 0 || start || pending_status.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered: %0d items over directed, index wrap and four gap phases",
			n_items);
		$display("results checked: %0d, mismatches: %0d", n_results, fails);
		if (fails == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// File: sim.f
design/c8fx_pkg.sv
design/c8fx_dp.sv
design/c8fx_ctrl.sv
design/chip8_fx_group_executor_top.sv
test/chip8_fx_group_executor_top_tb.sv
